FILE: hw/rtl/kld_pkg.sv
`default_nettype none
package kld_pkg;

  localparam int MapDepth = 8;
  localparam int MapWidth = 64;
  localparam int MapIdxW  = $clog2(MapDepth);
  localparam int BitIdxW  = $clog2(MapWidth);
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 2;

  typedef enum logic [2:0] {
    CMD_CHAR      = 3'd0,
    CMD_KEY_DOWN  = 3'd1,
    CMD_KEY_UP    = 3'd2,
    CMD_READ_DATA = 3'd3,
    CMD_READ_FLAG = 3'd4
  } kld_cmd_t;

  localparam logic [1:0] MODEL_ORIG   = 2'd0;
  localparam logic [1:0] MODEL_ENH    = 2'd1;
  localparam logic [1:0] MODEL_CLONE  = 2'd2;
  localparam logic [1:0] MODEL_ACCENT = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_MODEL = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAPS  = 1'd1;

  localparam logic [7:0] VKEY_LEFT   = 8'h25;
  localparam logic [7:0] VKEY_DELETE = 8'h2E;
  localparam logic [7:0] VKEY_SCROLL = 8'h91;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] key;
    logic       extended;
    logic       lock_on;
  } kld_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       strobe_res;
    logic       any_key_down;
  } kld_out_t;

  typedef struct packed {
    logic [1:0] machine_model;
    logic       caps_lock;
  } kld_cfg_t;

  typedef struct packed {
    logic any_before;
    logic any_after;
  } kld_map_stat_t;

  function automatic logic is_tracked_key(input logic [7:0] k);
    return k inside {8'h08, 8'h09, 8'h0D, 8'h1B, 8'h20, [8'h25:8'h28], 8'h2E,
                     [8'h30:8'h39], [8'h41:8'h5A], [8'h60:8'h6F],
                     [8'hBA:8'hC0], [8'hDB:8'hDF], 8'hE2};
  endfunction

  function automatic logic [MapIdxW-1:0] map_index(input logic [7:0] k, input logic ext);
    return {ext, k[7:6]};
  endfunction

  function automatic logic [7:0] accent_remap(input logic [7:0] k);
    logic [7:0] t;
    logic [7:0] r;
    t = (k >= 8'hC0 && k <= 8'hDA) ? k + 8'h20 : k;
    case (t)
      8'hE0:   r = 8'h5F;
      8'hE1:   r = 8'h40;
      8'hE2:   r = 8'h5C;
      8'hE3:   r = 8'h5B;
      8'hE7:   r = 8'h5D;
      8'hE9:   r = 8'h60;
      8'hEA:   r = 8'h26;
      8'hED:   r = 8'h7B;
      8'hF3:   r = 8'h7E;
      8'hF4:   r = 8'h7D;
      8'hF5:   r = 8'h23;
      8'hFA:   r = 8'h7C;
      default: r = t;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cursor_code(input logic [1:0] model, input logic [3:0] off);
    logic [7:0] n;
    n = 8'h00;
    case (off)
      4'd0:    n = 8'h08;
      4'd1:    n = (model == MODEL_ENH || model == MODEL_ACCENT) ? 8'h0B : 8'h00;
      4'd2:    n = 8'h15;
      4'd3:    n = (model == MODEL_ENH || model == MODEL_ACCENT) ? 8'h0A : 8'h00;
      4'd9:    n = (model == MODEL_ORIG) ? 8'h00 : 8'h7F;
      default: n = 8'h00;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/keyboard_latch_any_key_down.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  kld_in_t (cmd, key, extended, lock_on)
// out_      output     out_valid/out_stall  kld_out_t (read_value, strobe_res, any_key_down)
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A beat passes the map memory read, then the read-modify-write of the held-key map
// and the latch update. A new beat is taken every cycle while no output stall holds
// the work stage; a write and a read of the same map row in one cycle are forwarded.
// Reset clears the latch, strobe, accent mode and the per-row valid bits of the map.
// An output stall holds the work stage and, through it, stalls the input.
module keyboard_latch_any_key_down (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  kld_pkg::kld_in_t        in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output kld_pkg::kld_out_t             out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [kld_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire  [kld_pkg::CfgDataW-1:0]  cfg_data
);
  import kld_pkg::*;

  kld_cfg_t            cfg_r;
  logic                s1_vld_r;
  kld_in_t             s1_item_r;
  logic                s1_byp_r;
  logic [MapWidth-1:0] s1_byp_data_r;
  logic [MapDepth-1:0] nz_r, nz_nxt;
  logic                out_valid_r;
  kld_out_t            out_data_r;

  logic                in_acc, advance;
  logic [MapIdxW-1:0]  rd_idx, wr_idx;
  logic [MapWidth-1:0] rd_data, old_row, new_row, bit_mask;
  logic                rd_vld, wr_en, is_down, is_up;
  kld_map_stat_t       stat;
  kld_out_t            res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_vld_r && !advance;
  assign in_acc    = in_valid && !in_stall;
  assign rd_idx    = map_index(in_data.key, in_data.extended);
  assign wr_idx    = map_index(s1_item_r.key, s1_item_r.extended);

  always_comb begin
    is_down  = (s1_item_r.cmd == CMD_KEY_DOWN);
    is_up    = (s1_item_r.cmd == CMD_KEY_UP);
    old_row  = s1_byp_r ? s1_byp_data_r : (rd_vld ? rd_data : '0);
    bit_mask = MapWidth'(1) << s1_item_r.key[BitIdxW-1:0];
    new_row  = is_down ? (old_row | bit_mask) : (old_row & ~bit_mask);
    wr_en    = advance && (is_down || is_up) && is_tracked_key(s1_item_r.key);
    nz_nxt   = nz_r;
    if (wr_en) begin
      nz_nxt[wr_idx] = |new_row;
    end
    stat.any_before = |nz_r;
    stat.any_after  = |nz_nxt;
  end

  kld_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (new_row),
    .rd_en   (in_acc),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  kld_key_logic u_logic (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item_go (advance),
    .item    (s1_item_r),
    .stat    (stat),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.machine_model <= MODEL_ENH;
      cfg_r.caps_lock     <= 1'b1;
      s1_vld_r            <= 1'b0;
      s1_byp_r            <= 1'b0;
      nz_r                <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODEL: cfg_r.machine_model <= cfg_data[1:0];
          CFG_CAPS:  cfg_r.caps_lock     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        s1_byp_r <= wr_en && (wr_idx == rd_idx);
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      nz_r <= nz_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r     <= in_data;
      s1_byp_data_r <= new_row;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/kld_map_ram.sv
`default_nettype none
module kld_map_ram (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         wr_en,
  input  wire  [kld_pkg::MapIdxW-1:0]  wr_idx,
  input  wire  [kld_pkg::MapWidth-1:0] wr_data,
  input  wire                         rd_en,
  input  wire  [kld_pkg::MapIdxW-1:0]  rd_idx,
  output logic [kld_pkg::MapWidth-1:0] rd_data,
  output logic                        rd_vld
);
  import kld_pkg::*;

  logic [MapWidth-1:0] mem [MapDepth];
  logic [MapDepth-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld_r[rd_idx];
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/kld_key_logic.sv
`default_nettype none
module kld_key_logic (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire kld_pkg::kld_cfg_t cfg,
  input  wire                    item_go,
  input  wire kld_pkg::kld_in_t  item,
  input  wire kld_pkg::kld_map_stat_t stat,
  output kld_pkg::kld_out_t      res
);
  import kld_pkg::*;

  logic [6:0] latched_r, latched_nxt;
  logic       waiting_r, waiting_nxt;
  logic       accent_r, accent_nxt;

  logic       m3, newer, clone, reject, lower_k, lower_r;
  logic [7:0] k, code, remap, remap_up, ncode;
  logic [7:0] rv;

  always_comb begin
    k       = item.key;
    m3      = (cfg.machine_model == MODEL_ACCENT);
    newer   = (cfg.machine_model == MODEL_ENH) || m3;
    clone   = (cfg.machine_model == MODEL_CLONE) || m3;
    lower_k = (k >= 8'h61) && (k <= 8'h7A);
    remap   = accent_remap(k);
    lower_r = (remap >= 8'h61) && (remap <= 8'h7A);
    remap_up = (lower_r && cfg.caps_lock) ? (remap & 8'hDF) : remap;
    ncode   = cursor_code(cfg.machine_model, 4'(k - VKEY_LEFT));

    reject = m3 && k[7] && !accent_r;
    if (newer) begin
      reject = reject || (!clone && k[7]);
      code   = (cfg.caps_lock && lower_k) ? (k & 8'hDF) : k;
    end else begin
      reject = reject || (!clone && (k == 8'h60 || k >= 8'h7B));
      code   = lower_k ? (k & 8'hDF) : k;
    end

    latched_nxt = latched_r;
    waiting_nxt = waiting_r;
    accent_nxt  = accent_r;
    rv          = 8'h00;

    case (item.cmd)
      CMD_CHAR: begin
        if (!reject) begin
          latched_nxt = code[6:0];
          if (m3 && accent_r) begin
            if (!remap[7]) begin
              latched_nxt = remap_up[6:0];
              waiting_nxt = 1'b1;
            end
          end else begin
            waiting_nxt = 1'b1;
          end
        end
      end
      CMD_KEY_DOWN: begin
        if (k == VKEY_SCROLL) begin
          if (m3) begin
            accent_nxt = item.lock_on;
          end
        end else if (k >= VKEY_LEFT && k <= VKEY_DELETE && ncode != 8'h00) begin
          latched_nxt = ncode[6:0];
          waiting_nxt = 1'b1;
        end
      end
      CMD_READ_DATA: begin
        rv = {waiting_r, latched_r};
      end
      CMD_READ_FLAG: begin
        waiting_nxt = 1'b0;
        rv = {newer && stat.any_before, latched_r};
      end
      default: begin
      end
    endcase

    res.read_value   = rv;
    res.strobe_res   = waiting_nxt;
    res.any_key_down = stat.any_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= '0;
      waiting_r <= 1'b0;
      accent_r  <= 1'b0;
    end else if (item_go) begin
      latched_r <= latched_nxt;
      waiting_r <= waiting_nxt;
      accent_r  <= accent_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
  import kld_pkg::*;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BEATS_PER_SETTING = 52;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kld_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kld_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predicted state of the keyboard port.
  logic [1:0] mdl;
  logic caps;
  logic [6:0] code;
  logic waiting;
  logic accent;
  logic [63:0] held [8];

  kld_in_t stim_q [$];
  kld_out_t result_q [$];
  logic [8:0] down_keys [$];
  kld_out_t want;
  logic in_took = 1'b0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned in_idle_pct = 20;
  int unsigned out_idle_pct = 20;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned reg_writes = 0;

  keyboard_latch_any_key_down u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic lower_case(input logic [7:0] k);
    return k >= 8'h61 && k <= 8'h7A;
  endfunction

  function automatic logic keys_held();
    logic any;
    any = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (held[i] != 64'd0) begin
        any = 1'b1;
      end
    end
    return any;
  endfunction

  task automatic mark_key(input logic [7:0] k, input logic ext, input logic down);
    if (k == 8'h08 || k == 8'h09 || k == 8'h0D || k == 8'h1B || k == 8'h20 ||
        (k >= 8'h25 && k <= 8'h28) || k == 8'h2E || (k >= 8'h30 && k <= 8'h39) ||
        (k >= 8'h41 && k <= 8'h5A) || (k >= 8'h60 && k <= 8'h6F) ||
        (k >= 8'hBA && k <= 8'hC0) || (k >= 8'hDB && k <= 8'hDF) || k == 8'hE2) begin
      held[{ext, k[7:6]}][k[5:0]] = down;
    end
  endtask

  task automatic predict_beat(input kld_in_t it, output kld_out_t res);
    logic [7:0] k;
    logic [7:0] c;
    logic [7:0] r;
    logic [7:0] n;
    logic [7:0] rv;
    logic newer;
    logic clone;
    logic ok;
    k = it.key;
    rv = 8'h00;
    c = k;
    ok = 1'b1;
    newer = (mdl == MODEL_ENH || mdl == MODEL_ACCENT);
    clone = (mdl == MODEL_CLONE || mdl == MODEL_ACCENT);
    case (it.cmd)
      CMD_CHAR: begin
        if (mdl == MODEL_ACCENT && k > 8'h7F && !accent) begin
          ok = 1'b0;
        end else if (newer) begin
          ok = clone || k <= 8'h7F;
          c = (caps && lower_case(k)) ? k - 8'h20 : k;
        end else begin
          ok = clone || !(k == CH_BACKTICK || k >= CH_LBRACE);
          c = lower_case(k) ? k - 8'h20 : k;
        end
        if (ok) begin
          code = c[6:0];
          if (mdl == MODEL_ACCENT && accent) begin
            r = (k >= 8'hC0 && k <= 8'hDA) ? k + 8'h20 : k;
            case (r)
              8'hE0: r = 8'h5F;
              8'hE1: r = 8'h40;
              8'hE2: r = 8'h5C;
              8'hE3: r = 8'h5B;
              8'hE7: r = 8'h5D;
              8'hE9: r = 8'h60;
              8'hEA: r = 8'h26;
              8'hED: r = 8'h7B;
              8'hF3: r = 8'h7E;
              8'hF4: r = 8'h7D;
              8'hF5: r = 8'h23;
              8'hFA: r = 8'h7C;
              default: r = r;
            endcase
            if (r > 8'h7F) begin
              ok = 1'b0;
            end else begin
              if (caps && lower_case(r)) begin
                r = r - 8'h20;
              end
              code = r[6:0];
            end
          end
          if (ok) begin
            waiting = 1'b1;
          end
        end
      end
      CMD_KEY_DOWN: begin
        mark_key(k, it.extended, 1'b1);
        if (k == VKEY_SCROLL) begin
          if (mdl == MODEL_ACCENT) begin
            accent = it.lock_on;
          end
        end else if (k >= VKEY_LEFT && k <= VKEY_DELETE) begin
          case (k - VKEY_LEFT)
            8'd0: n = 8'h08;
            8'd1: n = newer ? 8'h0B : 8'h00;
            8'd2: n = 8'h15;
            8'd3: n = newer ? 8'h0A : 8'h00;
            8'd9: n = (mdl != MODEL_ORIG) ? 8'h7F : 8'h00;
            default: n = 8'h00;
          endcase
          if (n != 8'h00) begin
            code = n[6:0];
            waiting = 1'b1;
          end
        end
      end
      CMD_KEY_UP: mark_key(k, it.extended, 1'b0);
      CMD_READ_DATA: rv = {waiting, code};
      CMD_READ_FLAG: begin
        waiting = 1'b0;
        rv = {newer && keys_held(), code};
      end
      default: rv = 8'h00;
    endcase
    res.read_value = rv;
    res.strobe_res = waiting;
    res.any_key_down = keys_held();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mdl = MODEL_ENH;
      caps = 1'b1;
      code = 7'd0;
      waiting = 1'b0;
      accent = 1'b0;
      for (int i = 0; i < 8; i++) begin
        held[i] = 64'd0;
      end
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        if (cfg_index == CFG_MODEL) begin
          mdl = cfg_data[1:0];
        end else if (cfg_index == CFG_CAPS) begin
          caps = cfg_data[0];
        end
      end
      if (out_valid && !out_stall) begin
        beats_out++;
        if (result_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("tb_top: result beat with nothing expected: value %02h strobe %0b any %0b",
                     out_data.read_value, out_data.strobe_res, out_data.any_key_down);
          end
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_data.read_value !== want.read_value ||
              out_data.strobe_res !== want.strobe_res ||
              out_data.any_key_down !== want.any_key_down) begin
            if (mismatches < 10) begin
              $display("tb_top: beat %0d expected value %02h strobe %0b any %0b, got %02h %0b %0b",
                       beats_out, want.read_value, want.strobe_res, want.any_key_down,
                       out_data.read_value, out_data.strobe_res, out_data.any_key_down);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        beats_in++;
        predict_beat(in_data, want);
        result_q.push_back(want);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
        in_gap <= $urandom_range(8);
        in_valid <= 1'b0;
      end else begin
        in_data <= stim_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
      stall_left <= $urandom_range(8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, result_q.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic kld_in_t beat(input logic [2:0] cmd, input logic [7:0] key,
                                   input logic ext, input logic lock);
    kld_in_t it;
    it.cmd = cmd;
    it.key = key;
    it.extended = ext;
    it.lock_on = lock;
    return it;
  endfunction

  function automatic kld_in_t random_beat();
    kld_in_t it;
    int unsigned pick;
    int unsigned j;
    it.cmd = CMD_CHAR;
    it.key = 8'($urandom_range(255));
    it.extended = 1'($urandom_range(1));
    it.lock_on = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 30) begin
      j = $urandom_range(9);
      if (j < 5) begin
        it.key = 8'($urandom_range(8'h7F, 8'h20));
      end else if (j < 8) begin
        it.key = 8'($urandom_range(8'hFF, 8'hC0));
      end
    end else if (pick < 48) begin
      it.cmd = CMD_KEY_DOWN;
      j = $urandom_range(9);
      if (j < 5) begin
        it.key = 8'($urandom_range(VKEY_DELETE, VKEY_LEFT));
      end else if (j == 5) begin
        it.key = VKEY_SCROLL;
      end else if (j < 8) begin
        it.key = 8'($urandom_range(8'h5A, 8'h30));
      end
      if (j != 5) begin
        down_keys.push_back({it.extended, it.key});
      end
    end else if (pick < 66) begin
      it.cmd = CMD_KEY_UP;
      if (down_keys.size() != 0 && $urandom_range(3) != 0) begin
        j = $urandom_range(down_keys.size() - 1);
        {it.extended, it.key} = down_keys[j];
        down_keys.delete(j);
      end
    end else if (pick < 80) begin
      it.cmd = CMD_READ_DATA;
    end else if (pick < 95) begin
      it.cmd = CMD_READ_FLAG;
    end else begin
      it.cmd = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
    end
    return it;
  endfunction

  task automatic drain();
    do @(posedge clk); while (stim_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [1:0] set_model;
    logic set_caps;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: enhanced model with caps lock on.
    stim_q.push_back(beat(CMD_CHAR, 8'h61, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_READ_DATA, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_READ_FLAG, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_READ_DATA, 8'hFF, 1'b1, 1'b1));
    stim_q.push_back(beat(CMD_CHAR, 8'hFF, 1'b1, 1'b1));
    stim_q.push_back(beat(CMD_KEY_DOWN, 8'h26, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_KEY_DOWN, 8'h41, 1'b1, 1'b0));
    stim_q.push_back(beat(CMD_READ_FLAG, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_KEY_UP, 8'h41, 1'b1, 1'b0));
    stim_q.push_back(beat(CMD_KEY_UP, 8'h26, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_KEY_DOWN, 8'hFF, 1'b1, 1'b1));
    stim_q.push_back(beat(CMD_KEY_DOWN, VKEY_SCROLL, 1'b0, 1'b1));
    stim_q.push_back(beat(CMD_KEY_DOWN, 8'h2A, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_RSVD5, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_RSVD6, 8'hFF, 1'b1, 1'b1));
    stim_q.push_back(beat(CMD_RSVD7, 8'h55, 1'b0, 1'b1));
    stim_q.push_back(beat(CMD_KEY_DOWN, VKEY_DELETE, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_READ_DATA, 8'h00, 1'b0, 1'b0));
    drain();

    // Accent-mode clone, caps lock off.
    write_reg(CFG_MODEL, MODEL_ACCENT);
    write_reg(CFG_CAPS, 2'd0);
    stim_q.push_back(beat(CMD_CHAR, 8'hC1, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_KEY_DOWN, VKEY_SCROLL, 1'b0, 1'b1));
    stim_q.push_back(beat(CMD_CHAR, 8'hC1, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_READ_FLAG, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_CHAR, 8'hE5, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_READ_DATA, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_CHAR, 8'h71, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_KEY_DOWN, VKEY_SCROLL, 1'b0, 1'b0));
    stim_q.push_back(beat(CMD_KEY_UP, VKEY_DELETE, 1'b0, 1'b0));
    drain();

    for (int p = 0; p < 8; p++) begin
      set_model = 2'(p % 4);
      set_caps = 1'(p / 4);
      write_reg(CFG_MODEL, set_model);
      write_reg(CFG_CAPS, {1'b0, set_caps});
      in_idle_pct = (p % 3 == 1 || p == 7) ? 0 : $urandom_range(35, 1);
      out_idle_pct = (p % 3 == 2 || p == 7) ? 0 : $urandom_range(35, 1);
      for (int i = 0; i < BEATS_PER_SETTING; i++) begin
        stim_q.push_back(random_beat());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    mismatches += result_q.size();
    $display("tb_top: %0d beats in, %0d beats out, %0d register writes, all four models",
             beats_in, beats_out, reg_writes);
    $display("tb_top: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: keyboard_latch_any_key_down.f
hw/rtl/kld_pkg.sv
hw/rtl/kld_map_ram.sv
hw/rtl/kld_key_logic.sv
hw/rtl/keyboard_latch_any_key_down.sv
dv/tb_top.sv
